/* design/telemetry_frame_builder_crc8_assert.svh */
// Assertion macros shared by the telemetry frame builder modules.
// Needs nothing else; included by the modules that carry assertions.
`ifndef TELEMETRY_FRAME_BUILDER_CRC8_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_CRC8_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tfb_crc8_pkg.sv */
// Shared types, frame constants and the CRC-8 byte update for the frame builder.
// No dependencies; used by every module of the block.
package tfb_crc8_pkg;

    localparam int FRAME_LEN = 41;
    localparam int POS_W     = 6;
    localparam int PAYLOAD_BYTES = 24;

    localparam logic [7:0] MAGIC_A       = 8'h5A;
    localparam logic [7:0] MAGIC_B       = 8'hE1;
    localparam logic [7:0] FRAME_VERSION = 8'h01;
    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [15:0] PAYLOAD_LEN  = 16'd28;
    localparam logic [9:0] ENERGY_SCALE  = 10'd1000;

    // Byte positions inside the frame.
    localparam logic [POS_W-1:0] POS_MAGIC_A   = 6'd0;
    localparam logic [POS_W-1:0] POS_MAGIC_B   = 6'd1;
    localparam logic [POS_W-1:0] POS_VERSION   = 6'd2;
    localparam logic [POS_W-1:0] POS_FLAGS     = 6'd3;
    localparam logic [POS_W-1:0] POS_ZERO      = 6'd4;
    localparam logic [POS_W-1:0] POS_MAC0      = 6'd5;
    localparam logic [POS_W-1:0] POS_MAC1      = 6'd6;
    localparam logic [POS_W-1:0] POS_MAC2      = 6'd7;
    localparam logic [POS_W-1:0] POS_MAC3      = 6'd8;
    localparam logic [POS_W-1:0] POS_MAC4      = 6'd9;
    localparam logic [POS_W-1:0] POS_MAC5      = 6'd10;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 6'd11;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 6'd12;
    localparam logic [POS_W-1:0] POS_PAYLOAD   = 6'd13;
    localparam logic [POS_W-1:0] POS_RSVD0     = 6'd37;
    localparam logic [POS_W-1:0] POS_RSVD1     = 6'd38;
    localparam logic [POS_W-1:0] POS_RSVD2     = 6'd39;
    localparam logic [POS_W-1:0] POS_CRC       = 6'd40;

    // One scaled sample as it waits between front and back.
    typedef struct packed {
        logic        relay_on;
        logic        relay_command;
        logic [15:0] voltage;
        logic [23:0] current;
        logic [23:0] power;
        logic [15:0] power_factor;
        logic [15:0] frequency;
        logic [63:0] energy;
        logic [31:0] uptime;
    } t_sample;

    typedef logic [PAYLOAD_BYTES-1:0][7:0] t_payload;

    // CRC-8, MSB first, no reflection, one byte per call.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/tfb_crc8_front.sv */
// Front end: registers an accepted sample and scales power and energy.
// Depends on tfb_crc8_pkg; feeds tfb_crc8_queue.
module tfb_crc8_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_relay_on,
    input  logic                    i_relay_command,
    input  logic [15:0]             i_voltage_x10,
    input  logic [23:0]             i_current_milliamp,
    input  logic [20:0]             i_power_watts,
    input  logic [15:0]             i_power_factor_raw,
    input  logic [15:0]             i_frequency_x10,
    input  logic [30:0]             i_energy_kwh_x100,
    input  logic [31:0]             i_uptime_seconds,
    output logic                    o_push,
    input  logic                    i_push_ready,
    output tfb_crc8_pkg::t_sample   o_sample
);

    logic        r_valid;
    logic        r_relay_on;
    logic        r_relay_command;
    logic [15:0] r_voltage;
    logic [23:0] r_current;
    logic [20:0] r_power;
    logic [15:0] r_power_factor;
    logic [15:0] r_frequency;
    logic [30:0] r_energy;
    logic [31:0] r_uptime;

    logic [23:0] power_x10;
    logic [40:0] energy_x1000;
    logic        accept;

    assign o_ready = !r_valid || i_push_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;

    // Times ten as 8x + 2x; the product wraps to 24 bits.
    assign power_x10    = {r_power, 3'b000} + 24'({r_power, 1'b0});
    assign energy_x1000 = 41'(r_energy) * 41'(tfb_crc8_pkg::ENERGY_SCALE);

    always_comb begin
        o_sample.relay_on      = r_relay_on;
        o_sample.relay_command = r_relay_command;
        o_sample.voltage       = r_voltage;
        o_sample.current       = r_current;
        o_sample.power         = power_x10;
        o_sample.power_factor  = r_power_factor;
        o_sample.frequency     = r_frequency;
        o_sample.energy        = 64'(energy_x1000);
        o_sample.uptime        = r_uptime;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_relay_on      <= i_relay_on;
            r_relay_command <= i_relay_command;
            r_voltage       <= i_voltage_x10;
            r_current       <= i_current_milliamp;
            r_power         <= i_power_watts;
            r_power_factor  <= i_power_factor_raw;
            r_frequency     <= i_frequency_x10;
            r_energy        <= i_energy_kwh_x100;
            r_uptime        <= i_uptime_seconds;
        end
    end

endmodule

/* design/tfb_crc8_queue.sv */
// Small FIFO of scaled samples between the front end and the serializer.
// Depends on tfb_crc8_pkg and the assertion macro header.
`include "telemetry_frame_builder_crc8_assert.svh"
module tfb_crc8_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_push_ready,
    input  tfb_crc8_pkg::t_sample   i_data,
    output logic                    o_valid,
    input  logic                    i_pop,
    output tfb_crc8_pkg::t_sample   o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfb_crc8_pkg::t_sample r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_valid      = r_count != '0;
    assign o_data       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `TFB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `TFB_ASSERT_NEXT(a_push_held, i_clk, i_rst_n, i_push && !o_push_ready, i_push && $stable(i_data), "front dropped a waiting word")
    `TFB_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "serializer popped an empty queue")

endmodule

/* design/tfb_crc8_back.sv */
// Serializer: emits one frame word per cycle, while the output is not stalled, from a queued sample and the MAC,
// folding each word into the CRC. Depends on tfb_crc8_pkg and the macro header.
`include "telemetry_frame_builder_crc8_assert.svh"
module tfb_crc8_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [47:0]             i_mac,
    input  logic                    i_q_valid,
    output logic                    o_q_pop,
    input  tfb_crc8_pkg::t_sample   i_q_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_frame_byte,
    output logic [5:0]              o_byte_index,
    output logic                    o_last_byte
);

    localparam int IDX_W = $clog2(tfb_crc8_pkg::PAYLOAD_BYTES);

    tfb_crc8_pkg::t_sample r_rec;
    logic                  r_busy;
    logic [tfb_crc8_pkg::POS_W-1:0] r_pos;
    logic [7:0]            r_crc;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic [5:0]            r_out_index;
    logic                  r_out_last;

    tfb_crc8_pkg::t_payload payload;
    logic [IDX_W-1:0]      payload_idx;
    logic [7:0]            flags;
    logic [7:0]            cur_byte;
    logic                  at_last;
    logic                  advance;

    assign advance = !r_out_valid || i_ready;
    assign at_last = r_pos == tfb_crc8_pkg::POS_CRC;
    assign o_q_pop = advance && (!r_busy || at_last) && i_q_valid;

    // Measurements in frame order, each little-endian, lowest word first.
    assign payload = {r_rec.uptime, r_rec.energy, r_rec.frequency, r_rec.power_factor,
                      r_rec.power, r_rec.current, r_rec.voltage};
    assign payload_idx = IDX_W'(r_pos - tfb_crc8_pkg::POS_PAYLOAD);
    assign flags = {4'b0000, r_rec.relay_command, 1'b1, r_rec.relay_on, 1'b1};

    always_comb begin
        case (r_pos)
            tfb_crc8_pkg::POS_MAGIC_A: cur_byte = tfb_crc8_pkg::MAGIC_A;
            tfb_crc8_pkg::POS_MAGIC_B: cur_byte = tfb_crc8_pkg::MAGIC_B;
            tfb_crc8_pkg::POS_VERSION: cur_byte = tfb_crc8_pkg::FRAME_VERSION;
            tfb_crc8_pkg::POS_FLAGS:   cur_byte = flags;
            tfb_crc8_pkg::POS_ZERO:    cur_byte = 8'h00;
            tfb_crc8_pkg::POS_MAC0:    cur_byte = i_mac[47:40];
            tfb_crc8_pkg::POS_MAC1:    cur_byte = i_mac[39:32];
            tfb_crc8_pkg::POS_MAC2:    cur_byte = i_mac[31:24];
            tfb_crc8_pkg::POS_MAC3:    cur_byte = i_mac[23:16];
            tfb_crc8_pkg::POS_MAC4:    cur_byte = i_mac[15:8];
            tfb_crc8_pkg::POS_MAC5:    cur_byte = i_mac[7:0];
            tfb_crc8_pkg::POS_LEN_LO:  cur_byte = tfb_crc8_pkg::PAYLOAD_LEN[7:0];
            tfb_crc8_pkg::POS_LEN_HI:  cur_byte = tfb_crc8_pkg::PAYLOAD_LEN[15:8];
            tfb_crc8_pkg::POS_RSVD0:   cur_byte = 8'h00;
            tfb_crc8_pkg::POS_RSVD1:   cur_byte = 8'h00;
            tfb_crc8_pkg::POS_RSVD2:   cur_byte = 8'h00;
            tfb_crc8_pkg::POS_CRC:     cur_byte = r_crc;
            default:                   cur_byte = payload[payload_idx];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
            if (r_busy) begin
                // The first word of a frame restarts the CRC from zero.
                r_crc <= tfb_crc8_pkg::crc8_byte(
                    (r_pos == tfb_crc8_pkg::POS_MAGIC_A) ? 8'h00 : r_crc, cur_byte);
                r_pos <= r_pos + 1'b1;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (r_busy && at_last) begin
                r_busy <= 1'b0;
                r_pos  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_data;
        end
        if (advance && r_busy) begin
            r_out_byte  <= cur_byte;
            r_out_index <= r_pos;
            r_out_last  <= at_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_byte_index = r_out_index;
    assign o_last_byte  = r_out_last;

    `TFB_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, r_busy, r_pos <= tfb_crc8_pkg::POS_CRC, "frame position past the CRC word")
    `TFB_ASSERT_NOW(a_last_on_crc, i_clk, i_rst_n, o_valid, o_last_byte == (o_byte_index == tfb_crc8_pkg::POS_CRC), "last mark not on the CRC word")
    `TFB_ASSERT_NEXT(a_index_steps, i_clk, i_rst_n, o_valid && i_ready && !o_last_byte, o_valid && (o_byte_index == ($past(o_byte_index) + 6'd1)), "frame word missing or out of order")

endmodule

/* design/telemetry_frame_builder_crc8.sv */
// Telemetry frame builder: one sample in, a 41-word frame with CRC-8 out.
// Word 0 passes front register, queue and frame state to the output register.
// Frames go back to back; the serializer sends one word per cycle unless stalled.
// A queue of QUEUE_DEPTH samples lets the front take samples while a frame drains.
// Reset (synchronous, active low) empties the pipeline and clears the MAC to zero.
// Depends on tfb_crc8_pkg, tfb_crc8_front, tfb_crc8_queue and tfb_crc8_back.
module telemetry_frame_builder_crc8 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_mac_address,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_relay_on,
    input  logic        i_relay_command,
    input  logic [15:0] i_voltage_x10,
    input  logic [23:0] i_current_milliamp,
    input  logic [20:0] i_power_watts,
    input  logic [15:0] i_power_factor_raw,
    input  logic [15:0] i_frequency_x10,
    input  logic [30:0] i_energy_kwh_x100,
    input  logic [31:0] i_uptime_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic [5:0]  o_byte_index,
    output logic        o_last_byte
);

    logic [47:0]           r_mac;
    logic                  push;
    logic                  push_ready;
    tfb_crc8_pkg::t_sample push_data;
    logic                  q_valid;
    logic                  q_pop;
    tfb_crc8_pkg::t_sample q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= '0;
        end else if (i_cfg_valid) begin
            r_mac <= i_mac_address;
        end
    end

    tfb_crc8_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_relay_on         (i_relay_on),
        .i_relay_command    (i_relay_command),
        .i_voltage_x10      (i_voltage_x10),
        .i_current_milliamp (i_current_milliamp),
        .i_power_watts      (i_power_watts),
        .i_power_factor_raw (i_power_factor_raw),
        .i_frequency_x10    (i_frequency_x10),
        .i_energy_kwh_x100  (i_energy_kwh_x100),
        .i_uptime_seconds   (i_uptime_seconds),
        .o_push             (push),
        .i_push_ready       (push_ready),
        .o_sample           (push_data)
    );

    tfb_crc8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       (push_data),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_data       (q_data)
    );

    tfb_crc8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mac        (r_mac),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_data     (q_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

endmodule
